// File: src/lmd3_pkg.sv
// ============================================================================
// lmd3_pkg: shared types and constants of the 3x3 local maximum detector
// Holds the configuration register indexes, operation codes, the result
// record and the fixed field widths of the result channel.
// ============================================================================
package lmd3_pkg;

    // Fixed widths of the configuration registers and the result fields.
    localparam int CFG_BITS   = 11;
    localparam int ROW_BITS   = 11;
    localparam int COL_BITS   = 11;
    localparam int COUNT_BITS = 21;

    // Peak count saturates at its all-ones value.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(1024);

    // Result queue depth and its pointer and count widths.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    // Operation codes of an input request.
    typedef enum logic [0:0] {
        OP_VALUE = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    // One reported peak.
    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [COUNT_BITS-1:0] number;
    } t_peak;

endpackage

// File: src/lmd3_line_buf.sv
// ============================================================================
// lmd3_line_buf: two-row line buffer with read-during-write forwarding
// One entry per column holds both stored rows side by side. Reads are
// registered; a write to the address being read in the same cycle is
// forwarded to the read data of the next cycle.
// ============================================================================
module lmd3_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_BITS-1:0]     o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_BITS-1:0]     i_wdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_q;
    logic [DATA_BITS-1:0] r_fwd_data;
    logic                 r_fwd_hit;

    // Synchronous memory: the read returns the contents before this cycle's write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Remember a write that collides with the read so its data replaces the stale word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_re) begin
            r_fwd_hit <= i_we && (i_waddr == i_raddr);
        end
        if (i_re) begin
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_q;

    // A colliding write must show up in the next read data.
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_re && i_we && (i_waddr == i_raddr)) |=> (o_rdata == $past(i_wdata)))
        else $error("line buffer forwarding returned stale data");

    // A read with no colliding write returns the stored word.
    a_no_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_re && !(i_we && (i_waddr == i_raddr))) |=> (o_rdata == r_q))
        else $error("line buffer forwarded data without a collision");

    // Forward data is only selected after a read.
    a_hit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_hit) |-> $past(i_re))
        else $error("forward flag set without a read");

endmodule

// File: src/local_maximum_3x3_detector_top.sv
// ============================================================================
// local_maximum_3x3_detector_top: 3x3 strict local maximum detector
// Streams grid values in raster order and reports every cell that is
// strictly greater than its eight neighbors, with zero outside the grid.
// ============================================================================
// The block takes one request per clock cycle while input ready is high. A
// request is accepted into a three-stage pipeline: the first stage reads the
// line buffer at the current column, the second merges the two stored rows
// with the new value into the 3x3 window and writes the new value back, the
// third compares the window and pushes a report into a four-entry result
// queue, from which the report leaves once the receiver is ready. Input
// ready depends only on queue occupancy plus the requests still in flight,
// so a stalled output side holds back input only once four potential reports
// are pending. After the last grid row the source sends one row of flush
// requests; the end of that row clears the positions and the peak count.
// ============================================================================
module local_maximum_3x3_detector_top
    import lmd3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_addr,
    input  logic [CFG_BITS-1:0]          i_cfg_data,
    // Input request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_op,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ROW_BITS-1:0]          o_peak_row,
    output logic [COL_BITS-1:0]          o_peak_col,
    output logic [COUNT_BITS-1:0]        o_peak_number
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int VB = VALUE_BITS;

    // Configuration registers.
    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;

    // Stream position.
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;

    // Stage one: line buffer read in flight.
    logic                 r_s1_valid;
    logic [CW-1:0]        r_s1_col;
    logic [ROW_BITS-1:0]  r_s1_row;
    logic signed [VB-1:0] r_s1_value;
    logic                 r_s1_last;
    logic                 r_s1_pad;

    // Stage two: window ready for comparison.
    logic                 r_s2_valid;
    logic [CW-1:0]        r_s2_col;
    logic [ROW_BITS-1:0]  r_s2_row;
    logic                 r_s2_last;
    logic                 r_s2_pad;
    logic signed [VB-1:0] r_win [3][3];
    logic signed [VB-1:0] n_win [3][3];

    // Peak counter and result queue.
    logic [COUNT_BITS-1:0] r_count;
    t_peak                 r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_wr_ptr;
    logic [QPTR_BITS-1:0]  r_rd_ptr;
    logic [QCNT_BITS-1:0]  r_qcnt;

    logic                 accept;
    logic [WW-1:0]        width_eff;
    logic [CFG_BITS-1:0]  height_eff;
    logic                 pad;
    logic                 last;
    logic signed [VB-1:0] value_in;
    logic [2*VB-1:0]      lb_rdata;
    logic [2*VB-1:0]      lb_wdata;
    logic signed [VB-1:0] bank0;
    logic signed [VB-1:0] bank1;
    logic signed [VB-1:0] upper;
    logic signed [VB-1:0] middle;
    logic                 peak_mid;
    logic                 peak_right;
    logic                 hit_mid;
    logic                 hit_right;
    logic                 push;
    logic                 pop;
    logic [COUNT_BITS-1:0] count_inc;
    t_peak                push_data;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Effective geometry: zero width or height acts as one, width clamps to the buffer.
    assign width_eff  = (r_width == '0) ? WW'(1) :
                        (32'(r_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_width);
    assign height_eff = (r_height == '0) ? CFG_BITS'(1) : r_height;

    // Classify the request at the current position.
    assign pad      = (r_row >= height_eff);
    assign last     = ((WW'(r_col) + WW'(1)) >= width_eff);
    assign value_in = (pad || (t_op'(i_op) == OP_FLUSH)) ? '0 : i_value;

    // Ready counts queued reports and requests that may still produce one.
    assign o_in_ready = (r_qcnt + QCNT_BITS'(r_s1_valid) + QCNT_BITS'(r_s2_valid))
                        < QCNT_BITS'(QUEUE_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    // Position update and stage one registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (last) begin
                    r_col <= '0;
                    r_row <= pad ? '0 : r_row + ROW_BITS'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
        if (accept) begin
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_value <= value_in;
            r_s1_last  <= last;
            r_s1_pad   <= pad;
        end
    end

    // Line buffer: entry per column holding the rows of both parities.
    lmd3_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * VB)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (lb_rdata),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (lb_wdata)
    );

    // Pick the two rows above by parity and write the new value over the older one.
    assign bank0    = $signed(lb_rdata[VB-1:0]);
    assign bank1    = $signed(lb_rdata[2*VB-1:VB]);
    assign upper    = (r_s1_row >= ROW_BITS'(2)) ? (r_s1_row[0] ? bank1 : bank0) : '0;
    assign middle   = (r_s1_row >= ROW_BITS'(1)) ? (r_s1_row[0] ? bank0 : bank1) : '0;
    assign lb_wdata = r_s1_row[0] ? {r_s1_value, bank0} : {bank1, r_s1_value};

    // Window shift: a row start clears the window before the new column enters.
    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            for (int k = 0; k < 2; k++) begin
                n_win[rr][k] = (r_s1_col == '0) ? '0 : r_win[rr][k+1];
            end
        end
        n_win[0][2] = upper;
        n_win[1][2] = middle;
        n_win[2][2] = r_s1_value;
    end

    // Stage two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        if (r_s1_valid) begin
            r_win     <= n_win;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_last <= r_s1_last;
            r_s2_pad  <= r_s1_pad;
        end
    end

    // Strict maximum tests for the middle column and, at row end, the right column.
    always_comb begin
        peak_mid   = 1'b1;
        peak_right = !r_win[1][2][VB-1] && (r_win[1][2] != '0);
        for (int rr = 0; rr < 3; rr++) begin
            for (int k = 0; k < 3; k++) begin
                if (!(rr == 1 && k == 1)) begin
                    peak_mid = peak_mid && (r_win[1][1] > r_win[rr][k]);
                end
                if (k > 0 && !(rr == 1 && k == 2)) begin
                    peak_right = peak_right && (r_win[1][2] > r_win[rr][k]);
                end
            end
        end
    end

    assign hit_mid   = (r_s2_row != '0) && (r_s2_col != '0) && peak_mid;
    assign hit_right = (r_s2_row != '0) && r_s2_last && peak_right;
    assign push      = r_s2_valid && (hit_mid || hit_right);
    assign count_inc = (r_count < COUNT_MAX) ? r_count + COUNT_BITS'(1) : r_count;

    assign push_data.row    = r_s2_row;
    assign push_data.col    = hit_mid ? COL_BITS'(r_s2_col)
                                      : COL_BITS'(WW'(r_s2_col) + WW'(1));
    assign push_data.number = count_inc;

    // Peak counter: counts reports and clears when the padding row ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_last && r_s2_pad) begin
                r_count <= '0;
            end else if (push) begin
                r_count <= count_inc;
            end
        end
    end

    // Result queue.
    assign pop = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_qcnt   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            r_qcnt <= r_qcnt + QCNT_BITS'(push) - QCNT_BITS'(pop);
        end
        if (push) begin
            r_queue[r_wr_ptr] <= push_data;
        end
    end

    assign o_out_valid   = (r_qcnt != '0);
    assign o_peak_row    = r_queue[r_rd_ptr].row;
    assign o_peak_col    = r_queue[r_rd_ptr].col;
    assign o_peak_number = r_queue[r_rd_ptr].number;

    // Queued reports plus in-flight requests never exceed the queue.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt + QCNT_BITS'(r_s1_valid) + QCNT_BITS'(r_s2_valid))
            <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue may overflow");

    // A report is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (r_qcnt < QCNT_BITS'(QUEUE_DEPTH)))
        else $error("push into a full result queue");

    // Both candidate columns can never be peaks at once.
    a_single_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !(peak_mid && peak_right))
        else $error("adjacent cells both reported as strict maxima");

    // Reports carry a nonzero peak number and row.
    a_report_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_number != '0) && (o_peak_row != '0))
        else $error("report with zero peak number or row");

endmodule

// File: verif/tb.sv
// ============================================================================
// tb: self-checking testbench of the 3x3 local maximum detector
// Sends raster-order grids with flush padding rows through the valid/ready
// request channel and predicts every reported peak with its own model of the
// line buffers and the 3x3 window. Directed tests cover value extremes,
// flush requests inside the grid, degenerate and maximum sizes, register
// changes in the middle of a grid and output back-pressure. A random phase
// then runs many small grids with random sizes, contents and idle gaps.
// ============================================================================
module tb;
    import lmd3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH     = 1024;
    localparam int VALUE_BITS    = 16;
    localparam int RANDOM_ITEMS  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;

    // Content styles of random grid values.
    typedef enum int {
        VAL_FULL,
        VAL_TIES,
        VAL_NEG,
        VAL_EDGE,
        VAL_SPARSE
    } t_value_mode;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic [0:0]                   i_cfg_addr    = CFG_WIDTH;
    logic [CFG_BITS-1:0]          i_cfg_data    = '0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_ready;
    logic                         i_op          = OP_VALUE;
    logic signed [VALUE_BITS-1:0] i_value       = '0;
    logic                         o_out_valid;
    logic                         i_out_ready   = 1'b0;
    logic [ROW_BITS-1:0]          o_peak_row;
    logic [COL_BITS-1:0]          o_peak_col;
    logic [COUNT_BITS-1:0]        o_peak_number;

    // Predictor state: registers, line buffers, window and positions.
    logic [CFG_BITS-1:0]          width_reg  = WIDTH_RESET;
    logic [CFG_BITS-1:0]          height_reg = HEIGHT_RESET;
    logic signed [VALUE_BITS-1:0] line_mem [2][MAX_WIDTH];
    logic signed [VALUE_BITS-1:0] window [3][3];
    int unsigned                  col_pos    = 0;
    int unsigned                  row_pos    = 0;
    int unsigned                  peak_total = 0;

    t_peak       expected_peaks [$];
    int          mismatches   = 0;
    int unsigned items_sent   = 0;
    int          hold_request = 0;
    bit          no_idle      = 1'b0;
    int          cycle_count  = 0;

    local_maximum_3x3_detector_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_peak_row    (o_peak_row),
        .o_peak_col    (o_peak_col),
        .o_peak_number (o_peak_number)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        foreach (window[r, k]) window[r][k] = '0;
    end

    // Effective grid size after the out-of-range rules.
    function automatic int unsigned active_cols();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_rows();
        if (height_reg == 0) return 1;
        return height_reg;
    endfunction

    // Window cell; the column right of the window is zero padding.
    function automatic logic signed [VALUE_BITS-1:0] neighbor_at(input int r, input int k);
        if (k > 2) return '0;
        return window[r][k];
    endfunction

    // True when the middle-row cell at window column k beats all eight neighbors.
    function automatic bit strict_max(input int k);
        logic signed [VALUE_BITS-1:0] center;
        center = window[1][k];
        for (int r = 0; r < 3; r++)
            for (int d = -1; d <= 1; d++)
                if (!(r == 1 && d == 0) && !(center > neighbor_at(r, k + d)))
                    return 1'b0;
        return 1'b1;
    endfunction

    // Advances the predictor by one accepted request and returns any peak it decides.
    function automatic bit compute_peak(input t_op op, input logic signed [VALUE_BITS-1:0] val,
                                        output t_peak rpt);
        int unsigned                  cols, rows, c, r, hit_col;
        bit                           pad_row, row_end, found;
        logic signed [VALUE_BITS-1:0] fresh, upper, middle;
        cols    = active_cols();
        rows    = active_rows();
        c       = col_pos;
        r       = row_pos;
        pad_row = (r >= rows);
        row_end = (c + 1 >= cols);
        fresh   = (pad_row || op == OP_FLUSH) ? '0 : val;
        upper   = (r >= 2) ? line_mem[r & 1][c] : '0;
        middle  = (r >= 1) ? line_mem[(r + 1) & 1][c] : '0;
        found   = 1'b0;
        rpt     = '0;

        // Slide the window one column, restarting it at the row start.
        if (c == 0)
            foreach (window[i, j]) window[i][j] = '0;
        for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = upper;
        window[1][2] = middle;
        window[2][2] = fresh;
        line_mem[r & 1][c] = fresh;

        // Decide the cell above-left, and at the row end the last cell too.
        if (r >= 1) begin
            hit_col = 0;
            if (c >= 1 && strict_max(1))
                hit_col = c;
            else if (row_end && strict_max(2))
                hit_col = c + 1;
            if (hit_col != 0) begin
                if (peak_total < COUNT_MAX) peak_total++;
                rpt.row    = ROW_BITS'(r);
                rpt.col    = COL_BITS'(hit_col);
                rpt.number = COUNT_BITS'(peak_total);
                found      = 1'b1;
            end
        end

        // Step the positions; the end of the padding row starts a new grid.
        if (row_end) begin
            col_pos = 0;
            if (pad_row) begin
                row_pos    = 0;
                peak_total = 0;
                foreach (window[i, j]) window[i][j] = '0;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
        return found;
    endfunction

    // Idle gap before a request: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value(input t_value_mode mode);
        case (mode)
            VAL_TIES: return VALUE_BITS'($urandom_range(0, 5) - 2);
            VAL_NEG:  return VALUE_BITS'(0 - $urandom_range(1, 32768));
            VAL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sd0;
                    3:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            VAL_SPARSE: begin
                if ($urandom_range(0, 4) != 0) return '0;
                return VALUE_BITS'($urandom_range(1, 1000));
            end
            default:  return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Offers one request, holds it until accepted and records its prediction.
    task automatic send_item(input t_op op, input logic signed [VALUE_BITS-1:0] val);
        int    gap;
        t_peak rpt;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
        if (compute_peak(op, val, rpt)) expected_peaks.push_back(rpt);
    endtask

    // Stops offering requests and waits until every predicted peak has arrived or the drain limit runs out.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_peaks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers once the block is idle.
    task automatic write_cfg(input int unsigned cols, input int unsigned rows);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_WIDTH;
        i_cfg_data <= CFG_BITS'(cols);
        @(posedge i_clk);
        i_cfg_addr <= CFG_HEIGHT;
        i_cfg_data <= CFG_BITS'(rows);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg  = CFG_BITS'(cols);
        height_reg = CFG_BITS'(rows);
        @(posedge i_clk);
    endtask

    // One request of a well-formed grid, with a little noise mixed in.
    task automatic send_grid_item(input t_value_mode mode);
        if (row_pos >= active_rows()) begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_VALUE, pick_value(VAL_FULL));
            else
                send_item(OP_FLUSH, VALUE_BITS'($urandom));
        end else if ($urandom_range(0, 19) == 0) begin
            send_item(OP_FLUSH, VALUE_BITS'($urandom));
        end else begin
            send_item(OP_VALUE, pick_value(mode));
        end
    endtask

    task automatic finish_grid(input t_value_mode mode);
        while (row_pos != 0 || col_pos != 0) send_grid_item(mode);
    endtask

    task automatic send_grid(input t_value_mode mode);
        send_grid_item(mode);
        finish_grid(mode);
    endtask

    // Full-scale positive and negative values, peaks in corners and edges.
    task automatic test_value_extremes();
        logic signed [VALUE_BITS-1:0] cells [9] = '{
            16'sh7FFF, 16'sh8000, 16'sd1,
            16'sh8000, -16'sd1,   16'sh8000,
            16'sd0,    16'sh8000, 16'sh7FFF
        };
        write_cfg(3, 3);
        foreach (cells[i]) send_item(OP_VALUE, cells[i]);
        finish_grid(VAL_FULL);
    endtask

    // Flush requests inside the grid count as zero; values in the padding row are ignored.
    task automatic test_flush_inside_grid();
        write_cfg(2, 2);
        send_item(OP_VALUE, 16'sd5);
        send_item(OP_FLUSH, 16'sh7FFF);
        send_item(OP_FLUSH, 16'sh8000);
        send_item(OP_VALUE, 16'sd7);
        send_item(OP_VALUE, 16'sh7FFF);
        send_item(OP_FLUSH, 16'sd0);
    endtask

    // Zero width and zero height act as one; the peak number restarts per grid.
    task automatic test_degenerate_sizes();
        write_cfg(0, 0);
        send_item(OP_VALUE, 16'sd9);
        send_item(OP_VALUE, 16'sd100);
        send_item(OP_VALUE, -16'sd9);
        send_item(OP_FLUSH, 16'sd0);
        send_item(OP_VALUE, 16'sh7FFF);
        send_item(OP_FLUSH, 16'sh7FFF);
    endtask

    // Narrowing ends the current row early; lowering the height starts padding.
    task automatic test_config_mid_grid();
        write_cfg(5, 4);
        repeat (7) send_grid_item(VAL_FULL);
        write_cfg(2, 4);
        repeat (2) send_grid_item(VAL_FULL);
        write_cfg(2, 2);
        finish_grid(VAL_FULL);
    endtask

    // Widest grid, with a width above the maximum, and a tall narrow grid.
    task automatic test_size_extremes();
        write_cfg(2047, 1);
        send_grid(VAL_FULL);
        write_cfg(1, 40);
        send_grid(VAL_TIES);
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        write_cfg(16, 12);
        no_idle      = 1'b1;
        hold_request = 300;
        send_grid(VAL_FULL);
        no_idle      = 1'b0;
    endtask

    // Many small grids with random sizes and contents, some reconfigured mid-grid.
    task automatic test_random_grids();
        int unsigned start, cols, rows, pick, stop_at, n;
        t_value_mode mode;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                cols = $urandom_range(1, 12);
                rows = $urandom_range(1, 10);
            end else if (pick < 97) begin
                cols = $urandom_range(13, 64);
                rows = $urandom_range(1, 16);
            end else begin
                cols = $urandom_range(65, 256);
                rows = $urandom_range(1, 2);
            end
            if ($urandom_range(0, 19) == 0) cols = 0;
            if ($urandom_range(0, 19) == 0) rows = 0;
            mode    = t_value_mode'($urandom_range(0, 4));
            no_idle = ($urandom_range(0, 3) == 0);
            write_cfg(cols, rows);
            if ($urandom_range(0, 9) == 0) begin
                // Stop part way, then narrow the width or change the height.
                stop_at = $urandom_range(1, (cols + 1) * (rows + 1));
                n = 0;
                do begin
                    send_grid_item(mode);
                    n++;
                end while (n < stop_at && (row_pos != 0 || col_pos != 0));
                if (row_pos != 0 || col_pos != 0)
                    write_cfg($urandom_range(0, active_cols()), $urandom_range(0, rows + 2));
                finish_grid(mode);
            end else begin
                send_grid(mode);
            end
        end
        no_idle = 1'b0;
    endtask

    // Result receiver: random stalls, plus long hold-offs on request.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 40);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted peak with the oldest prediction.
    always @(posedge i_clk) begin
        t_peak got, want;
        got = '{row: o_peak_row, col: o_peak_col, number: o_peak_number};
        if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_peaks.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected peak: row %0d col %0d number %0d",
                             got.row, got.col, got.number);
            end else begin
                want = expected_peaks.pop_front();
                if (got.row !== want.row || got.col !== want.col
                        || got.number !== want.number) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("peak mismatch: expected row %0d col %0d number %0d, ",
                               want.row, want.col, want.number);
                        $display("got row %0d col %0d number %0d",
                                 got.row, got.col, got.number);
                    end
                end
            end
        end
    end

    // Hard limit on run length.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : test_sequence
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_value_extremes();
        test_flush_inside_grid();
        test_degenerate_sizes();
        test_config_mid_grid();
        test_size_extremes();
        test_output_backpressure();
        test_random_grids();

        drain_results();
        if (expected_peaks.size() != 0) begin
            $display("%0d predicted peaks never arrived", expected_peaks.size());
            mismatches += expected_peaks.size();
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
